>>> hw/rtl/gra_pkg.sv
// Package for the grid rectangle allocator: shared constants, result kinds and
// the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package gra_pkg;

    localparam int MAP_SIZE_DEF    = 256;
    localparam int SQUARE_SIZE_DEF = 16;

    localparam int REQ_W       = 9;
    localparam int ORG_W       = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_HIT,
        RES_ZERO
    } t_res;

    typedef struct packed {
        logic load;
        logic size_step;
        logic clr_wr;
        logic rd;
        logic scan_ev;
        logic mark_wr;
        logic res_load;
        t_res res_kind;
    } t_cmd;

    typedef struct packed {
        logic big;
        logic size_done;
        logic zero;
        logic hit;
        logic row_end;
        logic col_last;
        logic mark_last;
        logic clr_last;
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/grid_rectangle_allocator.sv
// Grid rectangle allocator top level: stream ports, controller and datapath.
// Depends on gra_pkg, gra_ctrl and gra_dp.
// Operation: sizing, then a scan that reads bitmap rows, up to GRID_DIM rows per
// candidate column over up to GRID_DIM - cw + 1 columns, then marking of the ch
// rows of the placed window (a read and a write per row), then the result.
// Throughput: one request at a time; the next is taken while a result waits.
// Reset: synchronous; a clearing pass over all GRID_DIM rows sets all squares free.
`default_nettype none

module grid_rectangle_allocator import gra_pkg::*; #(
    parameter int MAP_SIZE    = MAP_SIZE_DEF,
    parameter int SQUARE_SIZE = SQUARE_SIZE_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   i_s_axis_tdata,  // width_px[8:0], height_px[17:9]
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // placed[0], origin_x[8:1], origin_y[16:9]
);

    t_cmd             cmd;
    t_status          st;
    logic             placed;
    logic [ORG_W-1:0] origin_x, origin_y;

    gra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    gra_dp #(
        .MAP_SIZE    (MAP_SIZE),
        .SQUARE_SIZE (SQUARE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width_px  (i_s_axis_tdata[REQ_W-1:0]),
        .i_height_px (i_s_axis_tdata[2*REQ_W-1:REQ_W]),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_placed    (placed),
        .o_origin_x  (origin_x),
        .o_origin_y  (origin_y)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - 1 - 2*ORG_W){1'b0}}, origin_y, origin_x, placed};

endmodule

`default_nettype wire

>>> hw/rtl/gra_ctrl.sv
// Controller of the grid rectangle allocator: sequences clear, sizing, scan,
// marking and result hand-off. Depends on gra_pkg.
`default_nettype none

module gra_ctrl import gra_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_req_valid,
    output logic         o_req_ready,
    output logic         o_res_valid,
    input  wire          i_res_ready,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_res   r_kind,  n_kind;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_cmd.res_kind = r_kind;
        if (r_ovalid && i_res_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                priority if (i_st.big) begin
                    n_kind  = RES_FAIL;
                    n_state = S_DONE;
                end else if (i_st.size_done) begin
                    if (i_st.zero) begin
                        n_kind  = RES_ZERO;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    o_cmd.size_step = 1'b1;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                priority if (i_st.hit) begin
                    n_state = S_MARK_RD;
                end else if (i_st.row_end && i_st.col_last) begin
                    n_kind  = RES_FAIL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_MARK_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                if (i_st.mark_last) begin
                    n_kind  = RES_HIT;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MARK_RD;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_res_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_kind   <= RES_FAIL;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_ovalid;

endmodule

`default_nettype wire

>>> hw/rtl/gra_dp.sv
// Datapath of the grid rectangle allocator: free-square bitmap memory, size
// counters, scan counters, window mask and result register. Depends on gra_pkg.
`default_nettype none

module gra_dp import gra_pkg::*; #(
    parameter int MAP_SIZE    = MAP_SIZE_DEF,
    parameter int SQUARE_SIZE = SQUARE_SIZE_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [REQ_W-1:0]  i_width_px,
    input  wire [REQ_W-1:0]  i_height_px,
    input  wire t_cmd        i_cmd,
    output t_status          o_st,
    output logic             o_placed,
    output logic [ORG_W-1:0] o_origin_x,
    output logic [ORG_W-1:0] o_origin_y
);

    localparam int GRID_DIM = MAP_SIZE / SQUARE_SIZE;
    localparam int GRID_PX  = GRID_DIM * SQUARE_SIZE;
    localparam int AW       = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
    localparam int CW       = $clog2(GRID_DIM + 1);
    localparam int EW       = CW + 1;

    localparam logic [REQ_W-1:0] SQ    = REQ_W'(SQUARE_SIZE);
    localparam logic [AW-1:0]    LASTY = AW'(GRID_DIM - 1);
    localparam logic [EW-1:0]    GRIDE = EW'(GRID_DIM);

    logic [GRID_DIM-1:0] r_mem [GRID_DIM];
    logic [GRID_DIM-1:0] r_rdata;

    logic [REQ_W-1:0] r_w, r_h;
    logic             r_big;
    logic [CW-1:0]    r_cw, r_ch, r_run;
    logic [AW-1:0]    r_cx, r_cy, r_y;

    logic             r_placed;
    logic [ORG_W-1:0] r_ox, r_oy;

    logic [GRID_DIM-1:0] mask;
    logic [GRID_DIM-1:0] wdata;
    logic                wr_en;
    logic                row_ok;
    logic [EW-1:0]       run_inc;
    logic [EW-1:0]       cy_calc;
    logic [AW-1:0]       cy_n;
    logic [EW-1:0]       col_end;

    always_comb begin
        for (int i = 0; i < GRID_DIM; i++) begin
            mask[i] = (EW'(i) >= EW'(r_cx)) && (EW'(i) < (EW'(r_cx) + EW'(r_cw)));
        end
    end

    assign row_ok  = ((r_rdata & mask) == mask);
    assign run_inc = EW'(r_run) + EW'(1);
    assign cy_calc = EW'(r_y) + EW'(1) - EW'(r_ch);
    assign cy_n    = cy_calc[AW-1:0];
    assign col_end = EW'(r_cx) + EW'(r_cw);

    assign o_st.big       = r_big;
    assign o_st.size_done = (r_w == '0) && (r_h == '0);
    assign o_st.zero      = (r_cw == '0) || (r_ch == '0);
    assign o_st.hit       = row_ok && (run_inc == EW'(r_ch));
    assign o_st.row_end   = (r_y == LASTY);
    assign o_st.col_last  = (col_end == GRIDE);
    assign o_st.mark_last = (r_run == CW'(1));
    assign o_st.clr_last  = (r_y == LASTY);

    assign wr_en = i_cmd.clr_wr || i_cmd.mark_wr;
    assign wdata = i_cmd.clr_wr ? '1 : (r_rdata & ~mask);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_y] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_y];
        end
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_kind)
                RES_HIT: begin
                    r_placed <= 1'b1;
                    r_ox     <= ORG_W'(32'(r_cx) * SQUARE_SIZE);
                    r_oy     <= ORG_W'(32'(r_cy) * SQUARE_SIZE);
                end
                RES_ZERO: begin
                    r_placed <= 1'b1;
                    r_ox     <= '0;
                    r_oy     <= '0;
                end
                default: begin
                    r_placed <= 1'b0;
                    r_ox     <= '0;
                    r_oy     <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= '0;
            r_h   <= '0;
            r_big <= 1'b0;
            r_cw  <= '0;
            r_ch  <= '0;
            r_run <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_y   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_w   <= i_width_px;
                r_h   <= i_height_px;
                r_big <= (32'(i_width_px) > GRID_PX) || (32'(i_height_px) > GRID_PX);
                r_cw  <= '0;
                r_ch  <= '0;
                r_run <= '0;
                r_cx  <= '0;
                r_y   <= '0;
            end
            if (i_cmd.size_step) begin
                r_w  <= (r_w > SQ) ? (r_w - SQ) : '0;
                r_h  <= (r_h > SQ) ? (r_h - SQ) : '0;
                r_cw <= r_cw + CW'(r_w != '0);
                r_ch <= r_ch + CW'(r_h != '0);
            end
            if (i_cmd.clr_wr) begin
                r_y <= (r_y == LASTY) ? '0 : (r_y + AW'(1));
            end
            if (i_cmd.scan_ev) begin
                priority if (row_ok && (run_inc == EW'(r_ch))) begin
                    r_cy  <= cy_n;
                    r_y   <= cy_n;
                    r_run <= r_ch;
                end else if (r_y == LASTY) begin
                    if (col_end != GRIDE) begin
                        r_cx <= r_cx + AW'(1);
                    end
                    r_y   <= '0;
                    r_run <= '0;
                end else begin
                    r_y   <= r_y + AW'(1);
                    r_run <= row_ok ? run_inc[CW-1:0] : '0;
                end
            end
            if (i_cmd.mark_wr) begin
                r_y   <= r_y + AW'(1);
                r_run <= r_run - CW'(1);
            end
        end
    end

    assign o_placed   = r_placed;
    assign o_origin_x = r_ox;
    assign o_origin_y = r_oy;

endmodule

`default_nettype wire
